[rtl/core/assert_macros.svh]
// Assertion macros of the keyword finder RTL, used by the scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge out of reset.
`define KWF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true out of reset.
`define KWF_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define KWF_ASSERT(lbl, prop, msg)
`define KWF_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

[rtl/core/kwf_pkg.sv]
// Package: constants, types and helpers of the keyword finder.
`default_nettype none

package kwf_pkg;

    localparam int KEYWORD_MAX   = 8;
    localparam int POSITION_BITS = 16;
    localparam int DEPTH_BITS    = 8;

    localparam int COUNT_BITS     = $clog2(KEYWORD_MAX + 1);
    localparam int KW_CHARS_BITS  = 64;
    localparam int KW_LEN_BITS    = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_KEYWORD_CHARS  = 1'b0,
        REG_KEYWORD_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_STRAY     = 3'd2,
        ST_UNCLOSED  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } scan_status_t;

    localparam logic [7:0] CASE_FOLD     = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_LSQUARE    = 8'h5B;
    localparam logic [7:0] CH_RSQUARE    = 8'h5D;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  scan_status;
        logic [15:0] match_position;
    } out_item_t;

    // Handshake between input register and scanner
    typedef struct packed {
        logic valid;
        logic pop;
    } stage_ctl_t;

    function automatic logic is_word_char(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
            || (c == CH_UNDERSCORE);
    endfunction

endpackage

`default_nettype wire

[rtl/core/kwf_in_stage.sv]
// Input register of the keyword finder.
`default_nettype none

module kwf_in_stage
    import kwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    input  wire logic       s1_pop,
    output logic            s1_valid,
    output in_item_t        s1_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || s1_pop;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (s1_pop ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

[rtl/core/kwf_scanner.sv]
// Scan state, keyword registers and per-byte update logic.
`default_nettype none

`include "assert_macros.svh"

module kwf_scanner
    import kwf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  wire in_item_t                   s1_item,
    input  wire logic                       s1_valid,
    input  wire logic                       res_ready,
    output stage_ctl_t                      s1_ctl,
    output logic                            res_push,
    output out_item_t                       res_item
);

    localparam logic [DEPTH_BITS-1:0]    DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};
    localparam logic [KW_LEN_BITS-1:0]   LEN_CAP   = KW_LEN_BITS'(KEYWORD_MAX);

    logic [KW_CHARS_BITS-1:0] kw_chars_reg;
    logic [KW_LEN_BITS-1:0]   kw_len_reg;

    logic [COUNT_BITS-1:0]    matched_count_reg, matched_count_next;
    logic                     word_start_reg, word_start_next;
    logic                     in_string_reg, in_string_next;
    logic [DEPTH_BITS-1:0]    round_depth_reg, round_depth_next;
    logic [DEPTH_BITS-1:0]    square_depth_reg, square_depth_next;
    logic [POSITION_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic                     finished_reg, finished_next;
    scan_status_t             held_status_reg, held_status_next;
    logic [POSITION_BITS-1:0] held_pos_reg, held_pos_next;

    logic [KW_LEN_BITS-1:0]   len_eff;
    logic                     count_done;
    logic [2:0]               kw_idx;
    logic [7:0]               want_char;
    logic [7:0]               c;
    logic                     char_hit;
    logic                     pop;
    logic                     eot_pop;
    scan_status_t             final_status;
    logic [POSITION_BITS-1:0] final_pos;
    logic [31:0]              final_pos_wide;

    // Keyword registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_chars_reg <= '0;
            kw_len_reg   <= KW_LEN_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KEYWORD_CHARS:  kw_chars_reg <= cfg_data[KW_CHARS_BITS-1:0];
                REG_KEYWORD_LENGTH: kw_len_reg   <= cfg_data[KW_LEN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign c          = s1_item.text_byte;
    assign len_eff    = (kw_len_reg > LEN_CAP) ? LEN_CAP : kw_len_reg;
    assign count_done = KW_LEN_BITS'(matched_count_reg) >= len_eff;
    assign kw_idx     = 3'(matched_count_reg);
    assign want_char  = kw_chars_reg[{kw_idx, 3'b000} +: 8];
    assign char_hit   = !count_done && ((c | CASE_FOLD) == want_char);

    // Non-eot transfers never stall; eot waits for room in the result register
    assign pop        = s1_valid && (!s1_item.end_of_text || res_ready);
    assign eot_pop    = pop && s1_item.end_of_text;
    assign s1_ctl     = '{valid: s1_valid, pop: pop};

    // Outcome at end of text
    always_comb
    begin
        final_status = held_status_reg;
        final_pos    = held_pos_reg;
        if (!finished_reg)
        begin
            if ((round_depth_reg != '0) || (square_depth_reg != '0))
            begin
                final_status = ST_UNCLOSED;
            end
            else if (count_done)
            begin
                final_status = ST_FOUND;
                final_pos    = byte_pos_reg;
            end
            else
            begin
                final_status = ST_NOT_FOUND;
            end
        end
    end

    assign final_pos_wide = 32'(final_pos);
    assign res_push       = eot_pop;
    assign res_item.scan_status    = final_status;
    assign res_item.match_position = (final_status == ST_FOUND) ? final_pos_wide[15:0] : 16'd0;

    // Per-byte update
    always_comb
    begin
        matched_count_next = matched_count_reg;
        word_start_next    = word_start_reg;
        in_string_next     = in_string_reg;
        round_depth_next   = round_depth_reg;
        square_depth_next  = square_depth_reg;
        byte_pos_next      = byte_pos_reg;
        finished_next      = finished_reg;
        held_status_next   = held_status_reg;
        held_pos_next      = held_pos_reg;

        if (eot_pop)
        begin
            matched_count_next = '0;
            word_start_next    = 1'b1;
            in_string_next     = 1'b0;
            round_depth_next   = '0;
            square_depth_next  = '0;
            byte_pos_next      = '0;
            finished_next      = 1'b0;
            held_status_next   = ST_NOT_FOUND;
            held_pos_next      = '0;
        end
        else if (pop && !finished_reg)
        begin
            if (byte_pos_reg != POS_MAX)
            begin
                byte_pos_next = byte_pos_reg + 1'b1;
            end

            if (in_string_reg)
            begin
                if (c == CH_QUOTE)
                begin
                    in_string_next = 1'b0;
                end
            end
            else if (is_word_char(c))
            begin
                if (word_start_reg && (round_depth_reg == '0) && (square_depth_reg == '0))
                begin
                    if (char_hit)
                    begin
                        matched_count_next = matched_count_reg + 1'b1;
                    end
                    else
                    begin
                        matched_count_next = '0;
                        word_start_next    = 1'b0;
                    end
                end
            end
            else if (count_done)
            begin
                // keyword complete: takes priority over bracket handling
                finished_next    = 1'b1;
                held_status_next = ST_FOUND;
                held_pos_next    = byte_pos_reg;
            end
            else
            begin
                matched_count_next = '0;
                word_start_next    = 1'b1;
                case (c)
                    CH_QUOTE:
                    begin
                        in_string_next = 1'b1;
                    end
                    CH_LPAREN:
                    begin
                        if (round_depth_reg == DEPTH_MAX)
                        begin
                            finished_next    = 1'b1;
                            held_status_next = ST_OVERFLOW;
                            held_pos_next    = '0;
                        end
                        else
                        begin
                            round_depth_next = round_depth_reg + 1'b1;
                        end
                    end
                    CH_RPAREN:
                    begin
                        if (round_depth_reg == '0)
                        begin
                            finished_next    = 1'b1;
                            held_status_next = ST_STRAY;
                            held_pos_next    = '0;
                        end
                        else
                        begin
                            round_depth_next = round_depth_reg - 1'b1;
                        end
                    end
                    CH_LSQUARE:
                    begin
                        if (square_depth_reg == DEPTH_MAX)
                        begin
                            finished_next    = 1'b1;
                            held_status_next = ST_OVERFLOW;
                            held_pos_next    = '0;
                        end
                        else
                        begin
                            square_depth_next = square_depth_reg + 1'b1;
                        end
                    end
                    CH_RSQUARE:
                    begin
                        if (square_depth_reg == '0)
                        begin
                            finished_next    = 1'b1;
                            held_status_next = ST_STRAY;
                            held_pos_next    = '0;
                        end
                        else
                        begin
                            square_depth_next = square_depth_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_count_reg <= '0;
            word_start_reg    <= 1'b1;
            in_string_reg     <= 1'b0;
            round_depth_reg   <= '0;
            square_depth_reg  <= '0;
            byte_pos_reg      <= '0;
            finished_reg      <= 1'b0;
            held_status_reg   <= ST_NOT_FOUND;
            held_pos_reg      <= '0;
        end
        else
        begin
            matched_count_reg <= matched_count_next;
            word_start_reg    <= word_start_next;
            in_string_reg     <= in_string_next;
            round_depth_reg   <= round_depth_next;
            square_depth_reg  <= square_depth_next;
            byte_pos_reg      <= byte_pos_next;
            finished_reg      <= finished_next;
            held_status_reg   <= held_status_next;
            held_pos_reg      <= held_pos_next;
        end
    end

    `KWF_ASSERT_NEVER(a_count_bound, KW_LEN_BITS'(matched_count_reg) > LEN_CAP, "match count past keyword max")
    `KWF_ASSERT(a_clear_after_eot, res_push |=> (byte_pos_reg == '0) && !finished_reg && (round_depth_reg == '0) && (square_depth_reg == '0), "scan state not cleared after end of text")
    `KWF_ASSERT(a_finished_sticky, finished_reg && !eot_pop |=> finished_reg, "early outcome lost before end of text")
    `KWF_ASSERT(a_pos_frozen, finished_reg && !eot_pop |=> $stable(byte_pos_reg), "position moved after scan finished")

endmodule

`default_nettype wire

[rtl/core/kwf_out_stage.sv]
// Result register of the keyword finder.
`default_nettype none

module kwf_out_stage
    import kwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       res_push,
    input  wire out_item_t  res_item,
    output logic            res_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign res_ready  = !valid_reg || out_ready;
    assign valid_next = res_push ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            item_reg <= res_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = item_reg;

endmodule

`default_nettype wire

[rtl/core/top_level_keyword_finder.sv]
// Top level of the keyword finder: input register, scanner, result register.
`default_nettype none

// Scans a text one byte per transfer and reports, at end of text, whether a
// configured keyword (up to eight lower-case bytes, compared case-insensitively)
// occurs as a whole word outside quoted strings and round or square brackets,
// together with the byte index just after it. Other outcomes: not found, stray
// closing bracket, unclosed bracket and nesting overflow. Rate: one byte per
// clock unless an end-of-text transfer waits; the scan state updates from the
// input register at each transfer, so a transfer may follow every cycle. An
// end-of-text byte goes via the input and result registers to out_valid.
// Bytes never wait in the input register; an end-of-text transfer waits there
// only while the result register still holds an untaken result, and holds off
// the next input transfer meanwhile. Write the keyword registers through
// cfg_we/cfg_index/cfg_data only when the block is idle.

module top_level_keyword_finder
    import kwf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire in_item_t                   in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output out_item_t                       out_data
);

    logic       s1_valid;
    in_item_t   s1_item;
    stage_ctl_t s1_ctl;
    logic       res_push;
    logic       res_ready;
    out_item_t  res_item;

    // Input register: decouples the upstream transfer from the scanner
    kwf_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .s1_pop   (s1_ctl.pop),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    // Scan state and keyword registers; one byte per cycle unless an end-of-text byte waits
    kwf_scanner u_scanner
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s1_item   (s1_item),
        .s1_valid  (s1_valid),
        .res_ready (res_ready),
        .s1_ctl    (s1_ctl),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    // Result register: holds one outcome until the downstream transfer
    kwf_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_item  (res_item),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
